// File: design/ldm_pkg.sv
// Shared types, constants and arithmetic helpers for the lens distortion map.
package ldm_pkg;

	localparam int FRAC = 28;
	localparam logic signed [63:0] BIG = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC;
	localparam logic [31:0] FOCAL_MIN = 32'h0001_0000;
	localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int MUL_LAT = 4;
	localparam int DIV_BITS = 4;
	localparam int DIV_STAGES = 64 / DIV_BITS;
	localparam int DIV_LAT = DIV_STAGES + 1;

	// value with sticky saturation mark
	typedef struct packed {
		logic signed [63:0] v;
		logic s;
	} fx_t;

	typedef enum logic [2:0] {
		REG_FOCAL_X = 3'd0,
		REG_FOCAL_Y = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_RADIAL_K1 = 3'd4,
		REG_RADIAL_K2 = 3'd5,
		REG_RADIAL_K3 = 3'd6,
		REG_TANGENTIAL = 3'd7
	} cfg_idx_t;

	// saturating add, limits +-(2^63-1)
	function automatic fx_t addq(fx_t a, fx_t b);
		logic [64:0] sum;
		fx_t r;
		sum = {a.v[63], a.v} + {b.v[63], b.v};
		r.s = a.s | b.s;
		r.v = sum[63:0];
		if (!sum[64] && sum[63]) begin
			r.v = BIG;
			r.s = 1'b1;
		end else if (sum[64] && (!sum[63] || sum[63:0] == 64'h8000_0000_0000_0000)) begin
			r.v = -BIG;
			r.s = 1'b1;
		end
		return r;
	endfunction

	function automatic fx_t mk32(logic [31:0] w);
		fx_t r;
		r.v = {{32{w[31]}}, w};
		r.s = 1'b0;
		return r;
	endfunction

endpackage

// File: design/ldm_dly.sv
// Enabled delay line for aligning operands in the pipeline.
module ldm_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	assign q = line_s[N-1];

endmodule

// File: design/ldm_mul.sv
// Four-stage Q.28 multiplier with rounding, saturation and sticky mark.
module ldm_mul (
	input  logic          clk,
	input  logic          en,
	input  ldm_pkg::fx_t  a,
	input  ldm_pkg::fx_t  b,
	output ldm_pkg::fx_t  y
);

	logic [63:0] ma, mb;
	logic [63:0] pp0_s1, pp1_s1, pp2_s1, pp3_s1;
	logic neg_s1, zero_s1, sf_s1;
	logic [127:0] prod_s2;
	logic neg_s2, zero_s2, sf_s2;
	logic [127:0] rnd;
	logic [63:0] m_s3;
	logic over_s3, neg_s3, zero_s3, sf_s3;
	ldm_pkg::fx_t y_s4;

	assign ma = a.v[63] ? (~a.v + 64'd1) : a.v;
	assign mb = b.v[63] ? (~b.v + 64'd1) : b.v;
	assign rnd = prod_s2 + {100'd0, 1'b1, 27'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			pp0_s1 <= ma[31:0] * mb[31:0];
			pp1_s1 <= ma[31:0] * mb[63:32];
			pp2_s1 <= ma[63:32] * mb[31:0];
			pp3_s1 <= ma[63:32] * mb[63:32];
			neg_s1 <= a.v[63] ^ b.v[63];
			zero_s1 <= (a.v == '0) || (b.v == '0);
			if ((a.v == '0) || (b.v == '0)) begin
				sf_s1 <= (a.s && a.v != '0) || (b.s && b.v != '0);
			end else begin
				sf_s1 <= a.s | b.s;
			end

			prod_s2 <= {64'd0, pp0_s1} + {32'd0, pp1_s1, 32'd0} + {32'd0, pp2_s1, 32'd0}
				+ {pp3_s1, 64'd0};
			neg_s2 <= neg_s1;
			zero_s2 <= zero_s1;
			sf_s2 <= sf_s1;

			over_s3 <= (|rnd[127:92]) | rnd[91];
			m_s3 <= ((|rnd[127:92]) | rnd[91]) ? ldm_pkg::BIG : rnd[91:28];
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;
			sf_s3 <= sf_s2;

			if (zero_s3) begin
				y_s4.v <= '0;
				y_s4.s <= sf_s3;
			end else begin
				y_s4.v <= neg_s3 ? (~m_s3 + 64'd1) : m_s3;
				y_s4.s <= sf_s3 | over_s3;
			end
		end
	end

	assign y = y_s4;

endmodule

// File: design/ldm_div.sv
// Pipelined restoring divider for coordinate normalization, DIV_BITS per stage.
module ldm_div (
	input  logic          clk,
	input  logic          en,
	input  logic [63:0]   num,
	input  logic [31:0]   den,
	input  logic          neg,
	output ldm_pkg::fx_t  y
);

	localparam int NS = ldm_pkg::DIV_STAGES;
	localparam int BS = ldm_pkg::DIV_BITS;

	logic [32:0] rem_s [NS];
	logic [63:0] num_s [NS];
	logic [63:0] quo_s [NS];
	logic [31:0] den_s [NS];
	logic        neg_s [NS];
	ldm_pkg::fx_t y_so;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [32:0] rem_in, rem_n;
		logic [63:0] num_in, num_n, quo_in, quo_n;
		logic [31:0] den_in;
		logic        neg_in;

		if (g == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
			assign den_in = den;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign num_in = num_s[g-1];
			assign quo_in = quo_s[g-1];
			assign den_in = den_s[g-1];
			assign neg_in = neg_s[g-1];
		end

		always_comb begin
			rem_n = rem_in;
			num_n = num_in;
			quo_n = quo_in;
			for (int i = 0; i < BS; i++) begin
				rem_n = {rem_n[31:0], num_n[63]};
				num_n = {num_n[62:0], 1'b0};
				if (rem_n >= {1'b0, den_in}) begin
					rem_n = rem_n - {1'b0, den_in};
					quo_n = {quo_n[62:0], 1'b1};
				end else begin
					quo_n = {quo_n[62:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_n;
				num_s[g] <= num_n;
				quo_s[g] <= quo_n;
				den_s[g] <= den_in;
				neg_s[g] <= neg_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_so.v <= neg_s[NS-1] ? (~quo_s[NS-1] + 64'd1) : quo_s[NS-1];
			y_so.s <= 1'b0;
		end
	end

	assign y = y_so;

endmodule

// File: design/lens_distortion_map_top.sv
// Lens distortion map top: Brown-Conrady source coordinate for each pixel.
// Takes one (column, row) request per clock while not stalled and returns
// its Q16.16 source position through one input register, a divider for
// normalization, then a chain of four-stage multipliers and adders ending
// in the output register. The pipeline advances as one; when the output is
// held by the downstream side the whole pipeline, and s_tready, stall.
// Configuration must only be written with the pipeline empty.
module lens_distortion_map_top #(
	parameter int MAX_WIDTH = ldm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ldm_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // column[11:0], row[23:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // source_x[31:0], source_y[63:32]
	output logic        m_tuser,   // clipped
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [63:0] cfg_wdata
);

	localparam int LAT = 1 + ldm_pkg::DIV_LAT + 31;
	localparam int FXW = $bits(ldm_pkg::fx_t);

	logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [31:0] k1_q, k2_q, k3_q;
	logic [63:0] tang_q;
	logic [LAT-1:0] vld_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= ldm_pkg::FOCAL_MIN;
			focal_y_q <= ldm_pkg::FOCAL_MIN;
			center_x_q <= '0;
			center_y_q <= '0;
			k1_q <= '0;
			k2_q <= '0;
			k3_q <= '0;
			tang_q <= '0;
		end else if (cfg_we) begin
			case (ldm_pkg::cfg_idx_t'(cfg_addr))
				ldm_pkg::REG_FOCAL_X: focal_x_q <= cfg_wdata[31:0];
				ldm_pkg::REG_FOCAL_Y: focal_y_q <= cfg_wdata[31:0];
				ldm_pkg::REG_CENTER_X: center_x_q <= cfg_wdata[31:0];
				ldm_pkg::REG_CENTER_Y: center_y_q <= cfg_wdata[31:0];
				ldm_pkg::REG_RADIAL_K1: k1_q <= cfg_wdata[31:0];
				ldm_pkg::REG_RADIAL_K2: k2_q <= cfg_wdata[31:0];
				ldm_pkg::REG_RADIAL_K3: k3_q <= cfg_wdata[31:0];
				ldm_pkg::REG_TANGENTIAL: tang_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// constants seen by the datapath
	logic [31:0] fex, fey;
	ldm_pkg::fx_t k1, k2, k3, p1, p2, p1x2, p2x2, fex_v, fey_v, cx_v, cy_v, one_v;

	assign fex = (focal_x_q < ldm_pkg::FOCAL_MIN) ? ldm_pkg::FOCAL_MIN : focal_x_q;
	assign fey = (focal_y_q < ldm_pkg::FOCAL_MIN) ? ldm_pkg::FOCAL_MIN : focal_y_q;
	assign k1 = ldm_pkg::mk32(k1_q);
	assign k2 = ldm_pkg::mk32(k2_q);
	assign k3 = ldm_pkg::mk32(k3_q);
	assign p1 = ldm_pkg::mk32(tang_q[31:0]);
	assign p2 = ldm_pkg::mk32(tang_q[63:32]);
	assign p1x2 = '{v: p1.v <<< 1, s: 1'b0};
	assign p2x2 = '{v: p2.v <<< 1, s: 1'b0};
	assign fex_v = '{v: {32'd0, fex}, s: 1'b0};
	assign fey_v = '{v: {32'd0, fey}, s: 1'b0};
	assign cx_v = ldm_pkg::mk32(center_x_q);
	assign cy_v = ldm_pkg::mk32(center_y_q);
	assign one_v = '{v: ldm_pkg::ONE_Q, s: 1'b0};

	// input stage: clamp, center, numerator for division
	logic [11:0] colc, rowc;
	logic [33:0] numx, numy, magx, magy;
	logic [63:0] nx_s1, ny_s1;
	logic negx_s1, negy_s1;

	always_comb begin
		colc = s_tdata[11:0];
		rowc = s_tdata[23:12];
		if (int'(colc) >= MAX_WIDTH) colc = 12'(MAX_WIDTH - 1);
		if (int'(rowc) >= MAX_HEIGHT) rowc = 12'(MAX_HEIGHT - 1);
		numx = {6'd0, colc, 16'd0} - {{2{center_x_q[31]}}, center_x_q};
		numy = {6'd0, rowc, 16'd0} - {{2{center_y_q[31]}}, center_y_q};
		magx = numx[33] ? (~numx + 34'd1) : numx;
		magy = numy[33] ? (~numy + 34'd1) : numy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= {2'd0, magx[33:0], 28'd0} + {33'd0, fex[31:1]};
			ny_s1 <= {2'd0, magy[33:0], 28'd0} + {33'd0, fey[31:1]};
			negx_s1 <= numx[33];
			negy_s1 <= numy[33];
		end
	end

	ldm_pkg::fx_t x, y;

	ldm_div u_div_x (.clk, .en, .num(nx_s1), .den(fex), .neg(negx_s1), .y(x));
	ldm_div u_div_y (.clk, .en, .num(ny_s1), .den(fey), .neg(negy_s1), .y(y));

	ldm_pkg::fx_t x2, y2, xy, txy1, txy2, r4, k1r2, psx, psy, r2d, r6, k2r4, k3r6, k2r4d;
	ldm_pkg::fx_t rad_ad, xd, yd, xrad, yrad, txy1d, txy2d, psxd, psyd, fdx, fdy;
	ldm_pkg::fx_t r2_s5, x2d_s5, y2d_s5, sx_s6, sy_s6, ra_s10, rb_s18, rad_s19;
	ldm_pkg::fx_t dx1_s24, dy1_s24, dx_s25, dy_s25, px_s30, py_s30;
	logic [31:0] src_x_s31, src_y_s31;
	logic clip_s31;

	ldm_mul u_mul_x2 (.clk, .en, .a(x), .b(x), .y(x2));
	ldm_mul u_mul_y2 (.clk, .en, .a(y), .b(y), .y(y2));
	ldm_mul u_mul_xy (.clk, .en, .a(x), .b(y), .y(xy));

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s5 <= ldm_pkg::addq(x2, y2);
			x2d_s5 <= ldm_pkg::addq(x2, x2);
			y2d_s5 <= ldm_pkg::addq(y2, y2);
			sx_s6 <= ldm_pkg::addq(r2_s5, x2d_s5);
			sy_s6 <= ldm_pkg::addq(r2_s5, y2d_s5);
		end
	end

	ldm_mul u_mul_t1 (.clk, .en, .a(p1x2), .b(xy), .y(txy1));
	ldm_mul u_mul_t2 (.clk, .en, .a(p2x2), .b(xy), .y(txy2));
	ldm_mul u_mul_r4 (.clk, .en, .a(r2_s5), .b(r2_s5), .y(r4));
	ldm_mul u_mul_k1 (.clk, .en, .a(k1), .b(r2_s5), .y(k1r2));
	ldm_mul u_mul_psx (.clk, .en, .a(p2), .b(sx_s6), .y(psx));
	ldm_mul u_mul_psy (.clk, .en, .a(p1), .b(sy_s6), .y(psy));

	ldm_dly #(.W(FXW), .N(4)) u_dly_r2 (.clk, .en, .d(r2_s5), .q(r2d));
	ldm_mul u_mul_r6 (.clk, .en, .a(r4), .b(r2d), .y(r6));
	ldm_mul u_mul_k2 (.clk, .en, .a(k2), .b(r4), .y(k2r4));
	ldm_mul u_mul_k3 (.clk, .en, .a(k3), .b(r6), .y(k3r6));
	ldm_dly #(.W(FXW), .N(4)) u_dly_k2 (.clk, .en, .d(k2r4), .q(k2r4d));
	ldm_dly #(.W(FXW), .N(8)) u_dly_ra (.clk, .en, .d(ra_s10), .q(rad_ad));

	always_ff @(posedge clk) begin
		if (en) begin
			ra_s10 <= ldm_pkg::addq(one_v, k1r2);
			rb_s18 <= ldm_pkg::addq(k2r4d, k3r6);
			rad_s19 <= ldm_pkg::addq(rad_ad, rb_s18);
		end
	end

	ldm_dly #(.W(FXW), .N(19)) u_dly_x (.clk, .en, .d(x), .q(xd));
	ldm_dly #(.W(FXW), .N(19)) u_dly_y (.clk, .en, .d(y), .q(yd));
	ldm_mul u_mul_xr (.clk, .en, .a(xd), .b(rad_s19), .y(xrad));
	ldm_mul u_mul_yr (.clk, .en, .a(yd), .b(rad_s19), .y(yrad));
	ldm_dly #(.W(FXW), .N(15)) u_dly_t1 (.clk, .en, .d(txy1), .q(txy1d));
	ldm_dly #(.W(FXW), .N(16)) u_dly_t2 (.clk, .en, .d(txy2), .q(txy2d));
	ldm_dly #(.W(FXW), .N(14)) u_dly_px (.clk, .en, .d(psx), .q(psxd));
	ldm_dly #(.W(FXW), .N(13)) u_dly_py (.clk, .en, .d(psy), .q(psyd));

	always_ff @(posedge clk) begin
		if (en) begin
			dx1_s24 <= ldm_pkg::addq(xrad, txy1d);
			dy1_s24 <= ldm_pkg::addq(yrad, psyd);
			dx_s25 <= ldm_pkg::addq(dx1_s24, psxd);
			dy_s25 <= ldm_pkg::addq(dy1_s24, txy2d);
		end
	end

	ldm_mul u_mul_fx (.clk, .en, .a(fex_v), .b(dx_s25), .y(fdx));
	ldm_mul u_mul_fy (.clk, .en, .a(fey_v), .b(dy_s25), .y(fdy));

	function automatic logic [32:0] clamp32(ldm_pkg::fx_t p);
		logic [32:0] r;
		if (p.s) begin
			r = {1'b1, p.v[63] ? ldm_pkg::OUT_MIN : ldm_pkg::OUT_MAX};
		end else if (!p.v[63] && (|p.v[62:31])) begin
			r = {1'b1, ldm_pkg::OUT_MAX};
		end else if (p.v[63] && !(&p.v[62:31])) begin
			r = {1'b1, ldm_pkg::OUT_MIN};
		end else begin
			r = {1'b0, p.v[31:0]};
		end
		return r;
	endfunction

	logic [32:0] cl_x, cl_y;
	assign cl_x = clamp32(px_s30);
	assign cl_y = clamp32(py_s30);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s30 <= ldm_pkg::addq(fdx, cx_v);
			py_s30 <= ldm_pkg::addq(fdy, cy_v);
			src_x_s31 <= cl_x[31:0];
			src_y_s31 <= cl_y[31:0];
			clip_s31 <= cl_x[32] | cl_y[32];
		end
	end

	assign m_tdata = {src_y_s31, src_x_s31};
	assign m_tuser = clip_s31;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted request not in pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during stall");

	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[31:0] == ldm_pkg::OUT_MAX
			|| m_tdata[31:0] == ldm_pkg::OUT_MIN || m_tdata[63:32] == ldm_pkg::OUT_MAX
			|| m_tdata[63:32] == ldm_pkg::OUT_MIN))
		else $error("clipped result not at a limit");

endmodule
